// ----- design/lspe_pkg.sv -----
// Shared types and constants for the LED serial pulse encoder.
`default_nettype none
package lspe_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);
  localparam int unsigned BitCntW     = $clog2(BitsPerByte + 1);
  localparam int unsigned PaddrW      = 4;
  localparam int unsigned PdataW      = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] RegZeroHigh = 2'd0;
  localparam logic [1:0] RegOneHigh  = 2'd1;
  localparam logic [1:0] RegPeriod   = 2'd2;

  localparam logic [7:0] ZeroHighReset = 8'd6;
  localparam logic [7:0] OneHighReset  = 8'd12;
  localparam logic [7:0] PeriodReset   = 8'd20;

  typedef struct packed {
    logic       byte_offered;
    logic [7:0] byte_value;
    logic       last_byte;
  } lspe_in_t;

  typedef struct packed {
    logic line_level;
    logic byte_taken;
    logic load_refused;
    logic holding_free;
    logic frame_done;
  } lspe_out_t;

  typedef struct packed {
    logic [7:0] zero_high_ticks;
    logic [7:0] one_high_ticks;
    logic [7:0] bit_period_ticks;
  } lspe_cfg_t;

endpackage
`default_nettype wire

// ----- design/lspe_queue.sv -----
// Short item queue between the input side and the pulse engine.
`default_nettype none
module lspe_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  lspe_pkg::lspe_in_t push_data_i,
  output logic              nonempty_o,
  input  logic              pop_i,
  output lspe_pkg::lspe_in_t pop_data_o
);
  import lspe_pkg::*;

  lspe_in_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o     = (count_q == QueueCntW'(QueueDepth));
  assign nonempty_o = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/lspe_engine.sv -----
// Pulse engine: holding register, bit shifter, pulse timer and result register.
`default_nettype none
module lspe_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lspe_pkg::lspe_cfg_t cfg_i,
  input  logic                item_valid_i,
  output logic                item_pop_o,
  input  lspe_pkg::lspe_in_t  item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lspe_pkg::lspe_out_t out_data_o
);
  import lspe_pkg::*;

  logic [7:0]         shift_q, shift_d;
  logic [BitCntW-1:0] bits_left_q, bits_left_d;
  logic [7:0]         phase_q, phase_d;
  logic               sending_q, sending_d;
  logic               cur_last_q, cur_last_d;
  logic [7:0]         held_byte_q;
  logic               held_valid_q, held_valid_d;
  logic               held_last_q, held_last_d;
  logic               out_valid_q;
  lspe_out_t          out_data_q;
  lspe_out_t          res;

  logic       step;
  logic       shifter_free;
  logic       held_consumed;
  logic       taken;
  logic [7:0] high_len;
  logic [8:0] phase_inc;

  // One tick per item; advance whenever an item is present and the result slot is free or drains.
  assign step       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = step;

  assign high_len  = shift_q[7] ? cfg_i.one_high_ticks : cfg_i.zero_high_ticks;
  assign phase_inc = {1'b0, phase_q} + 9'd1;

  always_comb begin
    shift_d       = shift_q;
    bits_left_d   = bits_left_q;
    phase_d       = phase_q;
    sending_d     = sending_q;
    cur_last_d    = cur_last_q;
    held_valid_d  = held_valid_q;
    held_last_d   = held_last_q;
    shifter_free  = !sending_q;
    held_consumed = 1'b0;
    taken         = 1'b0;
    res           = '0;

    if (sending_q) begin
      res.line_level = (phase_q < high_len);
      if (phase_inc >= {1'b0, cfg_i.bit_period_ticks}) begin
        phase_d = '0;
        shift_d = {shift_q[6:0], 1'b0};
        if (bits_left_q <= BitCntW'(1)) begin
          bits_left_d    = '0;
          sending_d      = 1'b0;
          res.frame_done = cur_last_q;
          cur_last_d     = 1'b0;
          shifter_free   = 1'b1;
        end else begin
          bits_left_d = bits_left_q - 1'b1;
        end
      end else begin
        phase_d = phase_inc[7:0];
      end
    end

    // Load the held byte into a free shifter with no gap.
    if (shifter_free && held_valid_q) begin
      shift_d       = held_byte_q;
      cur_last_d    = held_last_q;
      bits_left_d   = BitCntW'(BitsPerByte);
      phase_d       = '0;
      sending_d     = 1'b1;
      held_consumed = 1'b1;
    end

    if (item_i.byte_offered) begin
      res.load_refused = held_valid_q;
      taken            = !held_valid_q;
    end
    res.byte_taken = taken;

    if (held_consumed) begin
      held_valid_d = 1'b0;
    end
    if (taken) begin
      held_valid_d = 1'b1;
      held_last_d  = item_i.last_byte;
    end
    res.holding_free = !held_valid_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= '0;
      bits_left_q  <= '0;
      phase_q      <= '0;
      sending_q    <= 1'b0;
      cur_last_q   <= 1'b0;
      held_valid_q <= 1'b0;
      held_last_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (step) begin
        shift_q      <= shift_d;
        bits_left_q  <= bits_left_d;
        phase_q      <= phase_d;
        sending_q    <= sending_d;
        cur_last_q   <= cur_last_d;
        held_valid_q <= held_valid_d;
        held_last_q  <= held_last_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && taken) begin
      held_byte_q <= item_i.byte_value;
    end
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

// ----- design/led_serial_pulse_encoder.sv -----
// Top level of the one-wire LED pulse encoder with its register port.
//
// Each accepted transaction is one tick of the pulse timer and yields exactly one
// result: the line level for that tick plus holding-register status. The block
// takes one transaction per clock cycle while results are drained; a two-entry
// input queue feeds a pulse engine that, while its result slot is free or
// draining, does one tick of work per cycle into that registered slot.
// Timing registers (zero high, one high, bit period, in ticks) sit at byte
// addresses 0, 4 and 8 and should only be written while no transaction is
// outstanding.
`default_nettype none
module led_serial_pulse_encoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  lspe_pkg::lspe_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output lspe_pkg::lspe_out_t              out_data_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lspe_pkg::PaddrW-1:0]      paddr,
  input  logic [lspe_pkg::PdataW-1:0]      pwdata,
  output logic [lspe_pkg::PdataW-1:0]      prdata,
  output logic                             pready
);
  import lspe_pkg::*;

  lspe_cfg_t cfg_q;
  logic      cfg_we;
  logic [1:0] reg_idx;
  logic      q_full, q_nonempty, q_pop;
  lspe_in_t  q_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zero_high_ticks  <= ZeroHighReset;
      cfg_q.one_high_ticks   <= OneHighReset;
      cfg_q.bit_period_ticks <= PeriodReset;
    end else if (cfg_we) begin
      case (reg_idx)
        RegZeroHigh: cfg_q.zero_high_ticks  <= pwdata[7:0];
        RegOneHigh:  cfg_q.one_high_ticks   <= pwdata[7:0];
        RegPeriod:   cfg_q.bit_period_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegZeroHigh: prdata = {24'd0, cfg_q.zero_high_ticks};
      RegOneHigh:  prdata = {24'd0, cfg_q.one_high_ticks};
      RegPeriod:   prdata = {24'd0, cfg_q.bit_period_ticks};
      default:     prdata = '0;
    endcase
  end

  assign in_ready_o = !q_full;

  lspe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .full_o      (q_full),
    .push_data_i (in_data_i),
    .nonempty_o  (q_nonempty),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  lspe_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_nonempty),
    .item_pop_o   (q_pop),
    .item_i       (q_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

// ----- design/lspe_checker.sv -----
// Port-level checks for the LED pulse encoder, bound to the top level.
`default_nettype none
module lspe_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_o,
  input  logic                        out_valid_o,
  input  logic                        out_ready_i,
  input  lspe_pkg::lspe_out_t         out_data_o
);
  import lspe_pkg::*;

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A byte is either taken or refused, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.byte_taken && out_data_o.load_refused))
    else $error("byte both taken and refused");

  // A taken byte leaves the holding register full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_taken |-> !out_data_o.holding_free)
    else $error("holding register free right after a take");

  // An accepted transaction arriving at an empty result slot is followed by a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |-> ##[1:2] out_valid_o)
    else $error("no result after accepted transaction");

endmodule

bind led_serial_pulse_encoder lspe_checker u_lspe_checker (.*);
`default_nettype wire
